/* sv/packed_cosine_wave_core_assert.svh */
// ----------------------------------------------------------------------------
// packed cosine wave assertion macros
// shared concurrent assertion forms used by the core
// ----------------------------------------------------------------------------
`ifndef PACKED_COSINE_WAVE_CORE_ASSERT_SVH
`define PACKED_COSINE_WAVE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/pcw_pkg.sv */
// ----------------------------------------------------------------------------
// pcw_pkg
// shared types and constants of the packed cosine wave core
// ----------------------------------------------------------------------------
package pcw_pkg;

    localparam int MAG_W  = 55;
    localparam int RW     = 58;
    localparam int AW     = 36;
    localparam int XW     = 34;
    localparam int CFG_IW = 4;

    localparam logic [CFG_IW-1:0] REG_SCALE = 4'd0;
    localparam logic [CFG_IW-1:0] REG_MODE  = 4'd1;

    localparam logic [2:0] PACK_ABS   = 3'd0;
    localparam logic [2:0] PACK_TRUNC = 3'd1;
    localparam logic [2:0] PACK_SCALE = 3'd2;
    localparam logic [2:0] PACK_SLOPE = 3'd3;

    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

    function automatic logic [63:0] round_shr(input logic [63:0] v, input int s);
        logic [63:0] half;
        half = 64'd1 << (s - 1);
        return (v + half) >> s;
    endfunction

    localparam logic signed [AW-1:0] PI30   = AW'(round_shr(PI_Q60, 30));
    localparam logic signed [AW-1:0] HALF30 = AW'(round_shr(PI_Q60, 31));
    localparam logic signed [AW-1:0] TWO30  = AW'(round_shr(TWO_PI_Q60, 30));

    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [29:0] ATAN_Q30 [24] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    typedef struct packed {
        logic en;
        logic sel_pi;
    } ctl_t;

endpackage

/* sv/pcw_mod_cell.sv */
// ----------------------------------------------------------------------------
// pcw_mod_cell
// one step of the phase reduction: subtracts a shifted modulus when it fits
// ----------------------------------------------------------------------------
module pcw_mod_cell #(
    parameter logic [63:0] MOD_2PI = 64'd1,
    parameter logic [63:0] MOD_PI  = 64'd1,
    parameter int          SHIFT   = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pcw_pkg::ctl_t             ctl,
    input  logic                      valid_in,
    input  logic [pcw_pkg::MAG_W-1:0] r_in,
    output logic                      valid_out,
    output logic [pcw_pkg::MAG_W-1:0] r_out
);

    localparam logic [63:0] D2PI = MOD_2PI << SHIFT;
    localparam logic [63:0] DPI  = MOD_PI << SHIFT;

    logic [pcw_pkg::RW-1:0]    d;
    logic                      valid_reg;
    logic [pcw_pkg::MAG_W-1:0] r_reg;
    logic [pcw_pkg::MAG_W-1:0] r_next;

    always_comb
    begin
        d = ctl.sel_pi ? DPI[pcw_pkg::RW-1:0] : D2PI[pcw_pkg::RW-1:0];
        if ({3'b000, r_in} >= d)
        begin
            r_next = r_in - d[pcw_pkg::MAG_W-1:0];
        end
        else
        begin
            r_next = r_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            r_reg <= r_next;
        end
    end

    assign valid_out = valid_reg;
    assign r_out     = r_reg;

endmodule

/* sv/pcw_cordic_cell.sv */
// ----------------------------------------------------------------------------
// pcw_cordic_cell
// one rotation-mode cordic iteration with a fixed shift and angle
// ----------------------------------------------------------------------------
module pcw_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic                          neg_in,
    input  logic signed [pcw_pkg::XW-1:0] x_in,
    input  logic signed [pcw_pkg::XW-1:0] y_in,
    input  logic signed [pcw_pkg::XW-1:0] z_in,
    output logic                          valid_out,
    output logic                          neg_out,
    output logic signed [pcw_pkg::XW-1:0] x_out,
    output logic signed [pcw_pkg::XW-1:0] y_out,
    output logic signed [pcw_pkg::XW-1:0] z_out
);

    localparam logic signed [pcw_pkg::XW-1:0] ANG = {4'b0000, pcw_pkg::ATAN_Q30[IDX]};

    logic signed [pcw_pkg::XW-1:0] xs;
    logic signed [pcw_pkg::XW-1:0] ys;
    logic signed [pcw_pkg::XW-1:0] x_next;
    logic signed [pcw_pkg::XW-1:0] y_next;
    logic signed [pcw_pkg::XW-1:0] z_next;
    logic signed [pcw_pkg::XW-1:0] x_reg;
    logic signed [pcw_pkg::XW-1:0] y_reg;
    logic signed [pcw_pkg::XW-1:0] z_reg;
    logic                          neg_reg;
    logic                          valid_reg;

    always_comb
    begin
        xs = x_in >>> IDX;
        ys = y_in >>> IDX;
        if (z_in >= 0)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANG;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            neg_reg <= neg_in;
        end
    end

    assign valid_out = valid_reg;
    assign neg_out   = neg_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule

/* sv/packed_cosine_wave_core.sv */
// ----------------------------------------------------------------------------
// packed_cosine_wave_core
// cosine of distance times scale, packed into 0..1 by the configured mode
// throughput: one transaction per cycle; the reduction and cordic cells advance
// together and hold only while a finished result sits stalled at the output
// reset: scale_factor 1.0, pack_mode 2, pipeline emptied
// ----------------------------------------------------------------------------
`include "packed_cosine_wave_core_assert.svh"

module packed_cosine_wave_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       distance_valid,
    output logic                       distance_stall,
    input  logic signed [31:0]         distance,
    output logic                       level_valid,
    input  logic                       level_stall,
    output logic [16:0]                level,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pcw_pkg::CFG_IW-1:0] cfg_index,
    input  logic [23:0]                cfg_data
);

    localparam int          QB      = 54 - 2 * FRAC_BITS;
    localparam logic [63:0] MOD_2PI = pcw_pkg::round_shr(pcw_pkg::TWO_PI_Q60, 60 - 2 * FRAC_BITS);
    localparam logic [63:0] MOD_PI  = pcw_pkg::round_shr(pcw_pkg::PI_Q60, 60 - 2 * FRAC_BITS);
    localparam int          SHR     = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int          SHL     = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;

    localparam logic signed [18:0] ONE19  = 19'sd65536;
    localparam logic signed [18:0] HALF19 = 19'sd32768;
    localparam logic signed [pcw_pkg::XW-1:0] ONE_XW  = 34'sd65536;
    localparam logic signed [pcw_pkg::XW-1:0] RND_XW  = 34'sd8192;

    logic signed [23:0] scale_reg;
    logic [2:0]         mode_reg;

    logic               en;
    pcw_pkg::ctl_t      ctl;

    logic signed [55:0] p_reg;
    logic               v1_reg;
    logic [pcw_pkg::MAG_W-1:0] m_reg;
    logic               v2_reg;

    logic [pcw_pkg::MAG_W-1:0] r_chain [QB+1];
    logic                      rv_chain [QB+1];

    logic signed [pcw_pkg::AW-1:0] a0;
    logic signed [pcw_pkg::AW-1:0] a1_reg;
    logic signed [pcw_pkg::AW-1:0] a1_next;
    logic                          va_reg;
    logic signed [pcw_pkg::AW-1:0] a2_reg;
    logic signed [pcw_pkg::AW-1:0] a2_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic                          vb_reg;

    logic signed [pcw_pkg::XW-1:0] x_chain [CORDIC_STAGES+1];
    logic signed [pcw_pkg::XW-1:0] y_chain [CORDIC_STAGES+1];
    logic signed [pcw_pkg::XW-1:0] z_chain [CORDIC_STAGES+1];
    logic                          n_chain [CORDIC_STAGES+1];
    logic                          cv_chain [CORDIC_STAGES+1];

    logic signed [pcw_pkg::XW-1:0] xf;
    logic signed [pcw_pkg::XW-1:0] cw;
    logic signed [17:0]            c_reg;
    logic signed [17:0]            c_next;
    logic                          vp_reg;

    logic signed [18:0] c19;
    logic signed [18:0] lv;
    logic [16:0]        level_reg;
    logic [16:0]        level_next;
    logic               out_valid_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 24'sd65536;
            mode_reg  <= pcw_pkg::PACK_SCALE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcw_pkg::REG_SCALE: scale_reg <= $signed(cfg_data);
                pcw_pkg::REG_MODE:  mode_reg  <= cfg_data[2:0];
                default:            ;
            endcase
        end
    end

    // pipeline advance
    assign en             = !(out_valid_reg && level_stall);
    assign distance_stall = !en;
    assign ctl.en         = en;
    assign ctl.sel_pi     = (mode_reg == pcw_pkg::PACK_SLOPE);

    // product and magnitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= distance_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= distance * scale_reg;
            m_reg <= p_reg[55] ? pcw_pkg::MAG_W'(-p_reg) : pcw_pkg::MAG_W'(p_reg);
        end
    end

    // modulus reduction chain
    assign r_chain[0]  = m_reg;
    assign rv_chain[0] = v2_reg;

    for (genvar k = 0; k < QB; k++)
    begin : g_mod
        pcw_mod_cell #(
            .MOD_2PI (MOD_2PI),
            .MOD_PI  (MOD_PI),
            .SHIFT   (QB - 1 - k)
        ) u_mod (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .valid_in  (rv_chain[k]),
            .r_in      (r_chain[k]),
            .valid_out (rv_chain[k+1]),
            .r_out     (r_chain[k+1])
        );
    end

    // quadrant folding
    assign a0 = pcw_pkg::AW'((r_chain[QB] >> SHR) << SHL);

    always_comb
    begin
        a1_next = (a0 > pcw_pkg::PI30) ? pcw_pkg::TWO30 - a0 : a0;
        if (a1_reg > pcw_pkg::HALF30)
        begin
            a2_next  = pcw_pkg::PI30 - a1_reg;
            neg_next = 1'b1;
        end
        else
        begin
            a2_next  = a1_reg;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= rv_chain[QB];
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= a1_next;
            a2_reg  <= a2_next;
            neg_reg <= neg_next;
        end
    end

    // cordic chain
    assign x_chain[0]  = pcw_pkg::GAIN_Q30;
    assign y_chain[0]  = '0;
    assign z_chain[0]  = pcw_pkg::XW'(a2_reg);
    assign n_chain[0]  = neg_reg;
    assign cv_chain[0] = vb_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        pcw_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cv_chain[i]),
            .neg_in    (n_chain[i]),
            .x_in      (x_chain[i]),
            .y_in      (y_chain[i]),
            .z_in      (z_chain[i]),
            .valid_out (cv_chain[i+1]),
            .neg_out   (n_chain[i+1]),
            .x_out     (x_chain[i+1]),
            .y_out     (y_chain[i+1]),
            .z_out     (z_chain[i+1])
        );
    end

    // cosine to q16 with clamp
    always_comb
    begin
        xf = n_chain[CORDIC_STAGES] ? -x_chain[CORDIC_STAGES] : x_chain[CORDIC_STAGES];
        cw = (xf + RND_XW) >>> 14;
        if (cw > ONE_XW)
        begin
            c_next = 18'sd65536;
        end
        else if (cw < -ONE_XW)
        begin
            c_next = -18'sd65536;
        end
        else
        begin
            c_next = 18'(cw);
        end
    end

    // packing
    always_comb
    begin
        c19 = 19'(c_reg);
        case (mode_reg)
            pcw_pkg::PACK_ABS:   lv = (c19 < 0) ? -c19 : c19;
            pcw_pkg::PACK_TRUNC: lv = (c19 < 0) ? c19 + ONE19 : c19;
            pcw_pkg::PACK_SCALE: lv = (c19 + ONE19) >>> 1;
            pcw_pkg::PACK_SLOPE: lv = (c19 + ONE19) >>> 1;
            default:             lv = HALF19;
        endcase
        if (lv < 0)
        begin
            level_next = '0;
        end
        else if (lv > ONE19)
        begin
            level_next = 17'd65536;
        end
        else
        begin
            level_next = lv[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg        <= cv_chain[CORDIC_STAGES];
            out_valid_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg     <= c_next;
            level_reg <= level_next;
        end
    end

    assign level_valid = out_valid_reg;
    assign level       = level_reg;

    `PCW_ASSERT_NOW(a_level_range, clk, rst_n, level_valid, level <= 17'd65536,
        "level above one")
    `PCW_ASSERT_NOW(a_half_mode, clk, rst_n, level_valid && mode_reg[2], level == 17'd32768,
        "undefined pack mode not giving one half")
    `PCW_ASSERT_NOW(a_fold_range, clk, rst_n, vb_reg, a2_reg <= pcw_pkg::HALF30,
        "folded angle beyond a quarter turn")
    `PCW_ASSERT_NOW(a_empty_accepts, clk, rst_n, !level_valid, !distance_stall,
        "input stalled with an empty output")

endmodule

/* tb/packed_cosine_wave_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_cosine_wave_core_test
// Sends signed distances through the packed cosine wave core under many
// scale and pack-mode settings. A built-in CORDIC predictor works out each
// level when its distance is taken, and every level that comes out is checked
// in order against it. Idling on the input side and stalls on the output side
// change from phase to phase.
// ----------------------------------------------------------------------------
module packed_cosine_wave_core_test;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;
    localparam int DRAIN_CYCLES  = 60;
    localparam int ONE_Q16       = 65536;
    localparam longint GAIN_START = 652032874;

    localparam logic [pcw_pkg::CFG_IW-1:0] REG_SPARE =
        pcw_pkg::REG_MODE + pcw_pkg::CFG_IW'(1);
    localparam logic [pcw_pkg::CFG_IW-1:0] REG_TOP   = {pcw_pkg::CFG_IW{1'b1}};
    localparam logic [2:0]                 PACK_HALF = 3'd4;
    localparam logic [2:0]                 PACK_LAST = 3'd7;

    localparam longint ATAN_STEP [16] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    localparam logic signed [31:0] CORNER_DISTANCES [10] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd102944, 32'sd205887, 32'sd411775,
        32'sh7fffffff, 32'sh80000000, 32'sh55555555, 32'shaaaaaaaa
    };

    typedef struct {
        logic signed [31:0] position;
        logic [16:0]        level;
    } level_expect_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         distance_valid = 1'b0;
    logic                         distance_stall;
    logic signed [31:0]           distance = '0;
    logic                         level_valid;
    logic                         level_stall = 1'b0;
    logic [16:0]                  level;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [pcw_pkg::CFG_IW-1:0]   cfg_index = '0;
    logic [23:0]                  cfg_data = '0;

    logic signed [31:0]  queued_distances [$];
    level_expect_t       predicted_levels [$];
    level_expect_t       head;

    logic signed [23:0]  scale_shadow = 24'sh010000;
    logic [2:0]          mode_shadow = pcw_pkg::PACK_SCALE;

    bit                  in_taken = 1'b0;
    bit                  cfg_taken = 1'b0;
    bit                  sender_hold = 1'b0;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  errors = 0;
    int                  distances_taken = 0;
    int                  levels_checked = 0;
    int                  settings_used = 0;

    packed_cosine_wave_core #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .distance_valid(distance_valid),
        .distance_stall(distance_stall),
        .distance(distance),
        .level_valid(level_valid),
        .level_stall(level_stall),
        .level(level),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // cosine in q16 of a phase magnitude with 2*FRAC_BITS fractional bits
    function automatic longint cordic_cos_q16(input logic [63:0] mag,
                                              input logic [63:0] turn_q60);
        logic [63:0] modulus;
        logic [63:0] r;
        longint a, pi30, half30, two30, x, y, z, xs, ys, c;
        bit flip;
        modulus = (turn_q60 + (64'd1 << (59 - 2 * FRAC_BITS))) >> (60 - 2 * FRAC_BITS);
        r = mag % modulus;
        a = longint'(r >> (2 * FRAC_BITS - 30));
        pi30 = longint'((pcw_pkg::PI_Q60 + (64'd1 << 29)) >> 30);
        half30 = longint'((pcw_pkg::PI_Q60 + (64'd1 << 30)) >> 31);
        two30 = longint'((pcw_pkg::TWO_PI_Q60 + (64'd1 << 29)) >> 30);
        flip = 1'b0;
        if (a > pi30)
            a = two30 - a;
        if (a > half30)
        begin
            a = pi30 - a;
            flip = 1'b1;
        end
        x = GAIN_START;
        y = 0;
        z = a;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
        end
        if (flip)
            x = -x;
        c = (x + 8192) >>> 14;
        if (c > ONE_Q16)
            c = ONE_Q16;
        if (c < -ONE_Q16)
            c = -ONE_Q16;
        return c;
    endfunction

    function automatic logic [16:0] cosine_level(input logic signed [31:0] position,
                                                 input logic signed [23:0] scale,
                                                 input logic [2:0] mode);
        longint p, c, lvl;
        logic [63:0] mag;
        p = longint'(position) * longint'(scale);
        mag = (p < 0) ? -p : p;
        case (mode)
            pcw_pkg::PACK_ABS:
            begin
                c = cordic_cos_q16(mag, pcw_pkg::TWO_PI_Q60);
                lvl = (c >= 0) ? c : -c;
            end
            pcw_pkg::PACK_TRUNC:
            begin
                c = cordic_cos_q16(mag, pcw_pkg::TWO_PI_Q60);
                lvl = (c >= 0) ? c : c + ONE_Q16;
            end
            pcw_pkg::PACK_SCALE:
            begin
                c = cordic_cos_q16(mag, pcw_pkg::TWO_PI_Q60);
                lvl = (c + ONE_Q16) >>> 1;
            end
            pcw_pkg::PACK_SLOPE:
            begin
                c = cordic_cos_q16(mag, pcw_pkg::PI_Q60);
                lvl = (c + ONE_Q16) >>> 1;
            end
            default:
                lvl = ONE_Q16 / 2;
        endcase
        if (lvl < 0)
            lvl = 0;
        if (lvl > ONE_Q16)
            lvl = ONE_Q16;
        return lvl[16:0];
    endfunction

    function automatic logic signed [31:0] pick_distance();
        int r;
        r = $urandom_range(7, 0);
        case ($urandom_range(3, 0))
            0, 1: return $urandom;
            2: return $signed($urandom_range(2097152, 0)) - 32'sd1048576;
            default:
            begin
                case ($urandom_range(3, 0))
                    0: return 32'sh7fffffff - r;
                    1: return 32'sh80000000 + r;
                    2: return r;
                    default: return -r;
                endcase
            end
        endcase
    endfunction

    function automatic logic [23:0] pick_scale(input int phase);
        if (phase % 5 == 0)
        begin
            case ($urandom_range(4, 0))
                0: return 24'h7fffff;
                1: return 24'h800000;
                2: return 24'h000000;
                3: return 24'h000001;
                default: return 24'hffffff;
            endcase
        end
        if ($urandom_range(1, 0))
            return 24'($urandom);
        return 24'($signed($urandom_range(262144, 0)) - 131072);
    endfunction

    task automatic flag_level_error(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        errors++;
    endtask

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!distance_valid || in_taken)
            begin
                if (queued_distances.size() > 0 && !sender_hold
                    && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    distance_valid <= 1'b1;
                    distance <= queued_distances.pop_front();
                end
                else
                begin
                    distance_valid <= 1'b0;
                end
            end
            level_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // transaction monitor and checker
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        cfg_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_taken = 1'b1;
                if (cfg_index == pcw_pkg::REG_SCALE)
                    scale_shadow = cfg_data;
                else if (cfg_index == pcw_pkg::REG_MODE)
                    mode_shadow = cfg_data[2:0];
            end
            if (distance_valid && !distance_stall)
            begin
                in_taken = 1'b1;
                predicted_levels.push_back('{distance,
                    cosine_level(distance, scale_shadow, mode_shadow)});
                distances_taken++;
            end
            if (level_valid && !level_stall)
            begin
                if (predicted_levels.size() == 0)
                begin
                    flag_level_error($sformatf("level %0d with nothing pending", level));
                end
                else
                begin
                    head = predicted_levels.pop_front();
                    if (level !== head.level)
                        flag_level_error($sformatf(
                            "distance %0d scale %0d mode %0d: level %0d, want %0d",
                            head.position, scale_shadow, mode_shadow, level, head.level));
                    levels_checked++;
                end
            end
        end
    end

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (queued_distances.size() > 0 || distance_valid || predicted_levels.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pcw_pkg::CFG_IW-1:0] idx,
                             input logic [23:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [23:0] scale, input logic [2:0] mode,
                                  input bit spare);
        wait_idle();
        write_reg(pcw_pkg::REG_SCALE, scale);
        write_reg(pcw_pkg::REG_MODE, {21'($urandom), mode});
        if (spare)
            write_reg(pcw_pkg::CFG_IW'($urandom_range(REG_TOP, REG_SPARE)),
                      24'($urandom));
        settings_used++;
    endtask

    task automatic hold_until_empty();
        sender_hold = 1'b1;
        do
        begin
            @(negedge clk);
            #1;
        end
        while (distance_valid || predicted_levels.size() > 0);
        sender_hold = 1'b0;
    endtask

    initial
    begin
        int count;
        int mode;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: scale one, (c+1)/2
        settings_used++;
        for (int i = 0; i < 10; i++)
            queued_distances.push_back(CORNER_DISTANCES[i]);

        apply_settings(24'h010000, pcw_pkg::PACK_ABS, 1'b0);
        queued_distances.push_back(32'sd205887);
        queued_distances.push_back(-32'sd102944);
        apply_settings(24'h010000, pcw_pkg::PACK_TRUNC, 1'b0);
        queued_distances.push_back(32'sd205887);
        queued_distances.push_back(32'sd150000);
        apply_settings(24'h010000, pcw_pkg::PACK_SLOPE, 1'b0);
        queued_distances.push_back(32'sd205887);
        queued_distances.push_back(32'sd100000);
        apply_settings(24'h010000, PACK_HALF, 1'b0);
        queued_distances.push_back(32'sd0);
        queued_distances.push_back(32'sd12345);
        apply_settings(24'h010000, PACK_LAST, 1'b1);
        queued_distances.push_back(-32'sd777);
        apply_settings(24'h000000, pcw_pkg::PACK_SCALE, 1'b0);
        queued_distances.push_back(32'sh7fffffff);
        apply_settings(24'h7fffff, pcw_pkg::PACK_ABS, 1'b1);
        queued_distances.push_back(32'sh7fffffff);
        apply_settings(24'h800000, pcw_pkg::PACK_SLOPE, 1'b0);
        queued_distances.push_back(32'sh80000000);

        for (int ph = 0; ph < 16; ph++)
        begin
            mode = ph % 8;
            apply_settings(pick_scale(ph), 3'(mode), ph % 3 == 0);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 52;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 52;
                end
                default:
                begin
                    send_idle_pct = 6;
                    stall_pct = 6;
                end
            endcase
            count = (mode > pcw_pkg::PACK_SLOPE) ? 40 : 165;
            for (int k = 0; k < count; k++)
                queued_distances.push_back(pick_distance());
            if (ph == 1 || ph == 9)
            begin
                do
                begin
                    @(negedge clk);
                    #1;
                end
                while (queued_distances.size() > count / 2);
                hold_until_empty();
            end
        end

        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
        $display("covered %0d distances under %0d scale/mode settings, %0d levels checked",
                 distances_taken, settings_used, levels_checked);
        $display("pack modes 0..7, scale extremes and ignored register writes included");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
